>>> src/stbg_pkg.sv
// ----------------------------------------------------------------------------
// Sine tone byte generator package
// Shared constants, register indexes, sequencer states and the divisor
// function of the sine series.
// ----------------------------------------------------------------------------
package stbg_pkg;

  localparam int DEFAULT_PHASE_BITS     = 16;
  localparam int DEFAULT_AMPLITUDE_BITS = 16;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_SAMPLES_PER_WAVE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WAVE_COUNT       = 1'd1;

  localparam logic [15:0] SAMPLES_PER_WAVE_RST = 16'd64;
  localparam logic [15:0] WAVE_COUNT_RST       = 16'd1;

  // pi/2 in Q2.62
  localparam logic [63:0] HALF_PI_Q62 = 64'h6487_ED51_10B4_611A;

  // series terms after x itself: x^3 .. x^25
  localparam logic [3:0] SERIES_TERMS = 4'd12;

  localparam int CNT_W = 6;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PHASE,
    S_FOLD,
    S_MUL_X,
    S_SET_X2,
    S_MUL_X2,
    S_SAVE_X2,
    S_MUL_T,
    S_SET_DIV,
    S_DIV,
    S_ACC,
    S_SET_AMP,
    S_MUL_AMP,
    S_DONE
  } stbg_state_t;

  // (2n)(2n+1): divisor that turns term n-1 into term n
  function automatic logic [9:0] series_div(logic [3:0] n);
    logic [9:0] ev;
    logic [9:0] od;
    ev = 10'({n, 1'b0});
    od = 10'({n, 1'b1});
    return ev * od;
  endfunction

endpackage

>>> src/sine_tone_byte_generator.sv
// ----------------------------------------------------------------------------
// Sine tone byte generator
// Each tick yields the next 16-bit sine sample of a tone as two bytes, low
// byte first, until the set number of waves has been produced.
// ----------------------------------------------------------------------------
// A tick that produces a sample is taken only while the sequencer is idle;
// a tick that produces nothing leaves the sequencer idle. The sample is
// formed by a phase division and then by one bit-serial radix-2 shift-add
// multiplier, shared by all 15 products, and a restoring divider that forms
// the 12 quotients. The two bytes leave from an output register, so the next
// tick can be taken while they wait.
module sine_tone_byte_generator #(
  parameter int PHASE_BITS     = stbg_pkg::DEFAULT_PHASE_BITS,
  parameter int AMPLITUDE_BITS = stbg_pkg::DEFAULT_AMPLITUDE_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [stbg_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [stbg_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            restart,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      out_byte,
  output logic                            last
);
  import stbg_pkg::*;

  localparam logic [CNT_W-1:0]      PHASE_LAST = CNT_W'(PHASE_BITS - 1);
  localparam logic [CNT_W-1:0]      WORD_LAST  = '1;
  localparam logic [PHASE_BITS-2:0] QUARTER    = {1'b1, {(PHASE_BITS - 2){1'b0}}};
  localparam logic [63:0]           AMP_Q      = 64'((64'd1 << (AMPLITUDE_BITS - 1)) - 64'd1);

  stbg_state_t state, state_next;

  logic [15:0] samples_per_wave, wave_count, sample_index, waves_done;
  logic [15:0] period;
  logic        in_take, stopped, start, wrap;
  logic [15:0] idx_base, done_base, idx_cur, idx_inc;

  logic [15:0]           prem;
  logic [PHASE_BITS-1:0] phase;
  logic [63:0]           ma, mhi, mlo, term, sum, x2;
  logic [9:0]            rem;
  logic [CNT_W-1:0]      cnt;
  logic [3:0]            nterm;
  logic                  neg;
  logic [15:0]           out_sample;
  logic                  out_hi;

  logic [16:0]           p_r2;
  logic                  p_ge;
  logic [15:0]           p_rem_next;
  logic [1:0]            quad;
  logic [PHASE_BITS-2:0] angle;
  logic [63:0]           frac;
  logic [64:0]           m_sum;
  logic [63:0]           prod_q62;
  logic [9:0]            divisor;
  logic [10:0]           d_r2;
  logic                  d_ge;
  logic [9:0]            d_rem_next;
  logic [63:0]           sum_next;
  logic [17:0]           rnd;
  logic [15:0]           mag, signed_sample;
  logic                  cnt_last;

  // tick bookkeeping
  assign period    = (samples_per_wave == 16'd0) ? 16'd1 : samples_per_wave;
  assign in_take   = in_valid & ~in_stall;
  assign idx_base  = restart ? 16'd0 : sample_index;
  assign done_base = restart ? 16'd0 : waves_done;
  assign stopped   = done_base >= wave_count;
  assign idx_cur   = (idx_base >= period) ? 16'd0 : idx_base;
  assign idx_inc   = idx_cur + 16'd1;
  assign wrap      = idx_inc >= period;
  assign start     = in_take & ~stopped;

  always_ff @(posedge clk) begin
    if (rst) begin
      samples_per_wave <= SAMPLES_PER_WAVE_RST;
      wave_count       <= WAVE_COUNT_RST;
      sample_index     <= 16'd0;
      waves_done       <= 16'd0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_SAMPLES_PER_WAVE: samples_per_wave <= cfg_data;
          REG_WAVE_COUNT:       wave_count       <= cfg_data;
          default: ;
        endcase
      end
      if (in_take) begin
        if (stopped) begin
          sample_index <= idx_base;
          waves_done   <= done_base;
        end else begin
          sample_index <= wrap ? 16'd0 : idx_inc;
          // saturate the wave count
          if (wrap && done_base != 16'hFFFF) begin
            waves_done <= done_base + 16'd1;
          end else begin
            waves_done <= done_base;
          end
        end
      end
    end
  end

  // phase division, one quotient bit per cycle
  assign p_r2       = {prem, 1'b0};
  assign p_ge       = p_r2 >= {1'b0, period};
  assign p_rem_next = p_ge ? 16'(p_r2 - {1'b0, period}) : p_r2[15:0];

  // fold into the first quadrant
  assign quad  = phase[PHASE_BITS-1 -: 2];
  assign angle = quad[0] ? QUARTER - {1'b0, phase[PHASE_BITS-3:0]}
                         : {1'b0, phase[PHASE_BITS-3:0]};
  assign frac  = 64'(angle) << (64 - PHASE_BITS);

  // shift-add multiplier step, multiplier bits taken LSB first
  assign m_sum    = {1'b0, mhi} + (mlo[0] ? {1'b0, ma} : 65'd0);
  assign prod_q62 = {mhi[61:0], mlo[63:62]};

  // restoring divider step, dividend shifted out of term
  assign divisor    = series_div(nterm);
  assign d_r2       = {rem, term[63]};
  assign d_ge       = d_r2 >= {1'b0, divisor};
  assign d_rem_next = d_ge ? 10'(d_r2 - {1'b0, divisor}) : d_r2[9:0];

  assign sum_next = nterm[0] ? sum - term : sum + term;

  // add one half, at bit 61, and drop the fraction below bit 62
  assign rnd           = {1'b0, mhi[13:0], mlo[63:61]} + 18'd1;
  assign mag           = rnd[16:1];
  assign signed_sample = neg ? 16'(16'd0 - mag) : mag;

  assign cnt_last = cnt == WORD_LAST;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:    if (start) state_next = S_PHASE;
      S_PHASE:   if (cnt == PHASE_LAST) state_next = S_FOLD;
      S_FOLD:    state_next = S_MUL_X;
      S_MUL_X:   if (cnt_last) state_next = S_SET_X2;
      S_SET_X2:  state_next = S_MUL_X2;
      S_MUL_X2:  if (cnt_last) state_next = S_SAVE_X2;
      S_SAVE_X2: state_next = S_MUL_T;
      S_MUL_T:   if (cnt_last) state_next = S_SET_DIV;
      S_SET_DIV: state_next = S_DIV;
      S_DIV:     if (cnt_last) state_next = S_ACC;
      S_ACC:     state_next = (nterm == SERIES_TERMS) ? S_SET_AMP : S_MUL_T;
      S_SET_AMP: state_next = S_MUL_AMP;
      S_MUL_AMP: if (cnt_last) state_next = S_DONE;
      S_DONE:    if (!out_valid) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          prem <= idx_cur;
          cnt  <= '0;
        end
      end
      S_PHASE: begin
        prem  <= p_rem_next;
        phase <= {phase[PHASE_BITS-2:0], p_ge};
        cnt   <= cnt + 1'b1;
      end
      S_FOLD: begin
        ma  <= HALF_PI_Q62;
        mlo <= frac;
        mhi <= '0;
        cnt <= '0;
        neg <= quad[1];
      end
      S_MUL_X, S_MUL_X2, S_MUL_T, S_MUL_AMP: begin
        mhi <= m_sum[64:1];
        mlo <= {m_sum[0], mlo[63:1]};
        cnt <= cnt + 1'b1;
      end
      S_SET_X2: begin
        term <= prod_q62;
        sum  <= prod_q62;
        ma   <= prod_q62;
        mlo  <= prod_q62;
        mhi  <= '0;
        cnt  <= '0;
      end
      S_SAVE_X2: begin
        x2    <= prod_q62;
        ma    <= term;
        mlo   <= prod_q62;
        mhi   <= '0;
        cnt   <= '0;
        nterm <= 4'd1;
      end
      S_SET_DIV: begin
        term <= prod_q62;
        rem  <= '0;
        cnt  <= '0;
      end
      S_DIV: begin
        rem  <= d_rem_next;
        term <= {term[62:0], d_ge};
        cnt  <= cnt + 1'b1;
      end
      S_ACC: begin
        sum   <= sum_next;
        nterm <= nterm + 4'd1;
        ma    <= term;
        mlo   <= x2;
        mhi   <= '0;
        cnt   <= '0;
      end
      S_SET_AMP: begin
        ma  <= sum;
        mlo <= AMP_Q;
        mhi <= '0;
        cnt <= '0;
      end
      S_DONE: begin
        if (!out_valid) begin
          out_sample <= signed_sample;
        end
      end
      default: ;
    endcase
  end

  // output word register: low byte, then high byte
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      out_hi    <= 1'b0;
    end else if (state == S_DONE && !out_valid) begin
      out_valid <= 1'b1;
      out_hi    <= 1'b0;
    end else if (out_valid && !out_stall) begin
      if (out_hi) begin
        out_valid <= 1'b0;
      end else begin
        out_hi <= 1'b1;
      end
    end
  end

  always_comb begin
    in_stall = state != S_IDLE;
    out_byte = out_hi ? out_sample[15:8] : out_sample[7:0];
    last     = out_hi;
  end

endmodule

>>> tb/tb_sine_tone_byte_generator.sv
// ----------------------------------------------------------------------------
// Sine tone byte generator testbench
// Sends ticks into the generator and checks every output byte against a
// bit-exact predictor of the fixed-point sine. A directed sequence comes first,
// then random ticks and register settings under four idling modes.
// ----------------------------------------------------------------------------
module tb_sine_tone_byte_generator;

  import stbg_pkg::*;

  // a producing tick keeps the sequencer busy this long before its first byte
  localparam int SAMPLE_CYCLES = DEFAULT_PHASE_BITS + 1757;
  localparam int SETTLE_CYCLES = SAMPLE_CYCLES + 25;
  localparam logic [63:0] QUARTER_TURN_Q62 = 64'h6487_ED51_10B4_611A;
  localparam logic [63:0] TONE_AMPLITUDE = (64'd1 << (DEFAULT_AMPLITUDE_BITS - 1)) - 64'd1;
  localparam int RANDOM_BLOCKS = 8;
  localparam int TICKS_PER_BLOCK = 72;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_word_t;

  typedef enum logic {ROW_WRITE, ROW_TICK} row_kind_t;

  typedef struct {
    row_kind_t                 kind;
    logic [CFG_INDEX_W-1:0]    idx;
    logic [CFG_DATA_W-1:0]     data;
    bit                        restart;
    bit                        typed;
    bit                        makes;
    logic [15:0]               smp;
  } tick_row_t;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   restart = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [7:0]             out_byte;
  logic                   last;

  // predictor state and register copies
  logic [15:0] tone_period;
  logic [15:0] tone_wave_limit;
  logic [15:0] tone_index;
  logic [15:0] tone_waves_done;

  out_word_t expected_words[$];
  out_word_t seen_want;
  tick_row_t directed_rows[33];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int stall_burst = 0;
  int mismatch_count = 0;
  int words_checked = 0;
  int ticks_sent = 0;
  int samples_made = 0;
  int ticks_stopped = 0;
  int reg_writes = 0;

  sine_tone_byte_generator uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .restart   (restart),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .last      (last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Q2.62 product, truncated
  function automatic logic [63:0] q62_mul(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = 128'(a) * 128'(b);
    return p[125:62];
  endfunction

  function automatic logic [15:0] tone_sample(logic [15:0] j, logic [16:0] n);
    logic [31:0]  ph;
    logic [1:0]   quad;
    logic [13:0]  r;
    logic [14:0]  ang;
    logic [63:0]  x, x2, term, sum;
    logic [127:0] acc;
    logic [63:0]  mag;
    int           k;
    ph = {j, 16'd0} / 32'(n);
    quad = ph[15:14];
    r = ph[13:0];
    // fold into the first quadrant
    ang = quad[0] ? 15'd16384 - 15'(r) : 15'(r);
    x = q62_mul(QUARTER_TURN_Q62, 64'(ang) << 48);
    x2 = q62_mul(x, x);
    term = x;
    sum = x;
    for (k = 1; k <= 12; k++) begin
      term = q62_mul(term, x2) / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) sum = sum - term;
      else sum = sum + term;
    end
    acc = 128'(TONE_AMPLITUDE) * 128'(sum) + (128'd1 << 61);
    mag = acc[125:62];
    return quad[1] ? 16'(~mag[15:0] + 16'd1) : mag[15:0];
  endfunction

  task automatic tone_step(input bit rs, output bit made, output logic [15:0] smp);
    logic [16:0] n;
    n = (tone_period == 16'd0) ? 17'd1 : 17'(tone_period);
    made = 1'b0;
    smp = '0;
    if (rs) begin
      tone_index = '0;
      tone_waves_done = '0;
    end
    if (tone_waves_done >= tone_wave_limit) return;
    if (17'(tone_index) >= n) tone_index = '0;
    smp = tone_sample(tone_index, n);
    made = 1'b1;
    tone_index = tone_index + 16'd1;
    if (17'(tone_index) >= n) begin
      tone_index = '0;
      if (tone_waves_done != 16'hFFFF) tone_waves_done = tone_waves_done + 16'd1;
    end
  endtask

  function automatic tick_row_t wr(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    tick_row_t row;
    row = '{ROW_WRITE, idx, data, 1'b0, 1'b0, 1'b0, 16'd0};
    return row;
  endfunction

  function automatic tick_row_t tk(bit rs);
    tick_row_t row;
    row = '{ROW_TICK, '0, '0, rs, 1'b0, 1'b0, 16'd0};
    return row;
  endfunction

  function automatic tick_row_t tk_is(bit rs, logic [15:0] smp);
    tick_row_t row;
    row = '{ROW_TICK, '0, '0, rs, 1'b1, 1'b1, smp};
    return row;
  endfunction

  function automatic tick_row_t tk_none(bit rs);
    tick_row_t row;
    row = '{ROW_TICK, '0, '0, rs, 1'b1, 1'b0, 16'd0};
    return row;
  endfunction

  // hold the sender until all bytes are out and the sequencer has settled
  task automatic drain_all();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_words.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    drain_all();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_SAMPLES_PER_WAVE) tone_period = data;
    else if (idx == REG_WAVE_COUNT) tone_wave_limit = data;
    reg_writes++;
  endtask

  task automatic send_tick(bit rs, bit typed, bit makes, logic [15:0] typed_smp);
    bit          made;
    logic [15:0] smp;
    // long gaps now and then so the sender also goes quiet while the block is idle
    if (send_idle_pct != 0 && $urandom_range(5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 2000)) @(posedge clk);
    end
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    restart  <= rs;
    do @(posedge clk); while (in_stall);
    ticks_sent++;
    tone_step(rs, made, smp);
    if (typed) begin
      made = makes;
      smp = typed_smp;
    end
    if (made) begin
      expected_words.push_back('{smp[7:0], 1'b0});
      expected_words.push_back('{smp[15:8], 1'b1});
      samples_made++;
    end else begin
      ticks_stopped++;
    end
  endtask

  // receiver: random stall, plus rare long bursts that back up the output register
  always @(posedge clk) begin
    if (stall_burst != 0) begin
      stall_burst <= stall_burst - 1;
      out_stall <= 1'b1;
    end else if (recv_stall_pct >= 50 && $urandom_range(7999) == 0) begin
      stall_burst <= $urandom_range(500, 3000);
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word, expected none, got byte %02h last %0d",
                 $time, out_byte, last);
        mismatch_count++;
      end else begin
        seen_want = expected_words.pop_front();
        words_checked++;
        if (out_byte !== seen_want.data || last !== seen_want.last) begin
          $display("%0t: word mismatch, expected byte %02h last %0d, got byte %02h last %0d",
                   $time, seen_want.data, seen_want.last, out_byte, last);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    int               blk;
    int               t;
    bit               rs;
    logic [15:0]      np;
    logic [15:0]      nw;
    tone_period = SAMPLES_PER_WAVE_RST;
    tone_wave_limit = WAVE_COUNT_RST;
    tone_index = '0;
    tone_waves_done = '0;
    directed_rows = '{
      tk_is(1'b0, 16'h0000), tk_is(1'b1, 16'h0000),
      wr(REG_SAMPLES_PER_WAVE, 16'd4),
      tk_is(1'b0, 16'h7FFF), tk_is(1'b0, 16'h0000), tk_is(1'b0, 16'h8001),
      tk_none(1'b0), tk_is(1'b1, 16'h0000),
      wr(REG_WAVE_COUNT, 16'd0), tk_none(1'b1),
      wr(REG_SAMPLES_PER_WAVE, 16'd0), wr(REG_WAVE_COUNT, 16'd3),
      tk_is(1'b1, 16'h0000), tk_is(1'b0, 16'h0000), tk_is(1'b0, 16'h0000),
      tk_none(1'b0),
      wr(REG_SAMPLES_PER_WAVE, 16'hFFFF), wr(REG_WAVE_COUNT, 16'hFFFF),
      tk_is(1'b1, 16'h0000), tk(1'b0), tk(1'b0), tk(1'b0),
      // shorten the period under a running index
      wr(REG_SAMPLES_PER_WAVE, 16'd2),
      tk_is(1'b0, 16'h0000), tk_is(1'b0, 16'h0000),
      wr(REG_SAMPLES_PER_WAVE, 16'd3),
      tk(1'b1), tk(1'b0), tk(1'b0), tk(1'b0),
      wr(REG_SAMPLES_PER_WAVE, 16'd7),
      tk(1'b0), tk(1'b0)
    };
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE)
        set_reg(directed_rows[i].idx, directed_rows[i].data);
      else
        send_tick(directed_rows[i].restart, directed_rows[i].typed,
                  directed_rows[i].makes, directed_rows[i].smp);
    end

    for (blk = 0; blk < RANDOM_BLOCKS; blk++) begin
      drain_all();
      case (blk % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      case ($urandom_range(9))
        0:       np = 16'd0;
        1:       np = 16'hFFFF;
        2:       np = 16'($urandom_range(25, 65535));
        default: np = 16'($urandom_range(1, 24));
      endcase
      case ($urandom_range(19))
        0, 1:    nw = 16'd0;
        2, 3, 4: nw = 16'hFFFF;
        5, 6, 7: nw = 16'($urandom_range(5, 65535));
        default: nw = 16'($urandom_range(1, 4));
      endcase
      if ($urandom_range(1)) begin
        set_reg(REG_SAMPLES_PER_WAVE, np);
        set_reg(REG_WAVE_COUNT, nw);
      end else begin
        set_reg(REG_WAVE_COUNT, nw);
        set_reg(REG_SAMPLES_PER_WAVE, np);
      end
      for (t = 0; t < TICKS_PER_BLOCK; t++) begin
        // pause until every pending word has been delivered
        if ($urandom_range(39) == 0) begin
          in_valid <= 1'b0;
          do @(posedge clk); while (expected_words.size() != 0);
        end
        rs = ($urandom_range(9) == 0) ||
             (tone_waves_done >= tone_wave_limit && $urandom_range(3) == 0);
        send_tick(rs, 1'b0, 1'b0, 16'd0);
      end
    end

    drain_all();
    $display("%0d ticks sent: %0d produced a sample, %0d met a stopped tone",
             ticks_sent, samples_made, ticks_stopped);
    $display("%0d register writes, %0d words checked over four idling modes",
             reg_writes, words_checked);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("timeout with %0d words still pending", expected_words.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> files.f
src/stbg_pkg.sv
src/sine_tone_byte_generator.sv
tb/tb_sine_tone_byte_generator.sv
